// ===== design/hands_on_wheel_alert_fsm_defines.svh =====
// ---------------------------------------------------------------------------
// Hands-on-wheel alert assertion macros
// Shared assertion forms for the alert controller. Each macro expects the
// module to have a clock named clk and an active-low reset named rst_n.
// ---------------------------------------------------------------------------
`ifndef HANDS_ON_WHEEL_ALERT_FSM_DEFINES_SVH
`define HANDS_ON_WHEEL_ALERT_FSM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HWA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HWA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hwa_pkg.sv =====
// ---------------------------------------------------------------------------
// Hands-on-wheel alert package
// Types, codes and reset defaults shared by the alert controller modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hwa_pkg;

  // Operating mode, one-hot encoded.
  typedef enum logic [4:0] {
    M_INIT   = 5'b00001,
    M_WATCH  = 5'b00010,
    M_LIGHT  = 5'b00100,
    M_STRONG = 5'b01000,
    M_ERROR  = 5'b10000
  } mode_t;

  // Mode codes as reported on the result channel.
  localparam logic [2:0] MODE_CODE_INIT   = 3'd0;
  localparam logic [2:0] MODE_CODE_WATCH  = 3'd1;
  localparam logic [2:0] MODE_CODE_LIGHT  = 3'd2;
  localparam logic [2:0] MODE_CODE_STRONG = 3'd3;
  localparam logic [2:0] MODE_CODE_ERROR  = 3'd4;

  // Event codes.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_START    = 3'd1,
    EV_ONE_HAND = 3'd2,
    EV_LIGHT    = 3'd3,
    EV_HARSH    = 3'd4,
    EV_NO_HANDS = 3'd5,
    EV_EXPIRED  = 3'd6
  } event_t;

  // Buzzer codes.
  localparam logic [1:0] BUZ_OFF  = 2'd0;
  localparam logic [1:0] BUZ_INT  = 2'd1;
  localparam logic [1:0] BUZ_CONT = 2'd2;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_HAND_THR    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_THR   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HARSH_THR   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ONE_HAND    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALERT_TO    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_ERROR_TO    = 3'd6;

  // Register reset values.
  localparam int RST_HAND_THR  = 1366;
  localparam int RST_LIGHT_THR = 80;
  localparam int RST_HARSH_THR = 260;
  localparam int RST_INTERVAL  = 120;
  localparam int RST_ONE_HAND  = 2000;
  localparam int RST_ALERT_TO  = 2500;
  localparam int RST_ERROR_TO  = 5000;

  // One result item; the first member sits in the highest bits.
  typedef struct packed {
    logic       vibrator_on;
    logic [1:0] buzz_sel;
    logic [2:0] event_code;
    logic [2:0] mode;
  } result_t;

  localparam int RESULT_W = $bits(result_t);
  localparam int OUT_DW   = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== design/hwa_cfg.sv =====
// ---------------------------------------------------------------------------
// Hands-on-wheel alert configuration registers
// Seven write-only registers loaded through a plain write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hwa_cfg
  import hwa_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int TIMER_BITS  = 16,
  parameter int CFG_W       = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  output logic [SAMPLE_BITS-1:0] hand_thr,
  output logic [SAMPLE_BITS-1:0] light_thr,
  output logic [SAMPLE_BITS-1:0] harsh_thr,
  output logic [TIMER_BITS-1:0]  interval,
  output logic [TIMER_BITS-1:0]  one_hand_ms,
  output logic [TIMER_BITS-1:0]  alert_to,
  output logic [TIMER_BITS-1:0]  error_to
);

  logic [SAMPLE_BITS-1:0] hand_thr_r, light_thr_r, harsh_thr_r;
  logic [TIMER_BITS-1:0]  interval_r, one_hand_r, alert_to_r, error_to_r;
  logic [SAMPLE_BITS-1:0] wdata_s;
  logic [TIMER_BITS-1:0]  wdata_t;

  assign wdata_s = cfg_wdata[SAMPLE_BITS-1:0];
  assign wdata_t = cfg_wdata[TIMER_BITS-1:0];

  // Register write decode; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hand_thr_r  <= SAMPLE_BITS'(RST_HAND_THR);
      light_thr_r <= SAMPLE_BITS'(RST_LIGHT_THR);
      harsh_thr_r <= SAMPLE_BITS'(RST_HARSH_THR);
      interval_r  <= TIMER_BITS'(RST_INTERVAL);
      one_hand_r  <= TIMER_BITS'(RST_ONE_HAND);
      alert_to_r  <= TIMER_BITS'(RST_ALERT_TO);
      error_to_r  <= TIMER_BITS'(RST_ERROR_TO);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_HAND_THR:  hand_thr_r  <= wdata_s;
        CFG_LIGHT_THR: light_thr_r <= wdata_s;
        CFG_HARSH_THR: harsh_thr_r <= wdata_s;
        CFG_INTERVAL:  interval_r  <= wdata_t;
        CFG_ONE_HAND:  one_hand_r  <= wdata_t;
        CFG_ALERT_TO:  alert_to_r  <= wdata_t;
        CFG_ERROR_TO:  error_to_r  <= wdata_t;
        default: ;
      endcase
    end
  end

  assign hand_thr    = hand_thr_r;
  assign light_thr   = light_thr_r;
  assign harsh_thr   = harsh_thr_r;
  assign interval    = interval_r;
  assign one_hand_ms = one_hand_r;
  assign alert_to    = alert_to_r;
  assign error_to    = error_to_r;

endmodule

// ===== design/hwa_core.sv =====
// ---------------------------------------------------------------------------
// Hands-on-wheel alert core
// Mode state machine, elapsed timers, sensor classification and result encode.
// State advances once per item when adv is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hands_on_wheel_alert_fsm_defines.svh"

module hwa_core
  import hwa_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int TIMER_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic [SAMPLE_BITS-1:0] left_grip,
  input  logic [SAMPLE_BITS-1:0] right_grip,
  input  logic [SAMPLE_BITS-1:0] wheel_position,
  input  logic                   alarm_request,
  input  logic [SAMPLE_BITS-1:0] hand_thr,
  input  logic [SAMPLE_BITS-1:0] light_thr,
  input  logic [SAMPLE_BITS-1:0] harsh_thr,
  input  logic [TIMER_BITS-1:0]  interval,
  input  logic [TIMER_BITS-1:0]  one_hand_ms,
  input  logic [TIMER_BITS-1:0]  alert_to,
  input  logic [TIMER_BITS-1:0]  error_to,
  output result_t                result
);

  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  // State registers.
  mode_t                  mode_r, mode_nxt;
  logic [TIMER_BITS-1:0]  entry_r, entry_nxt;
  logic [TIMER_BITS-1:0]  ctrl_r, ctrl_nxt;
  logic                   oh_act_r, oh_act_nxt;
  logic [TIMER_BITS-1:0]  oh_r, oh_nxt;
  logic [SAMPLE_BITS-1:0] prev_wheel_r, prev_wheel_nxt;
  logic                   primed_r, primed_nxt;
  logic                   alarm_r, alarm_nxt;

  // Per-item intermediates.
  logic                   alarm_p;
  logic [TIMER_BITS-1:0]  entry_inc, ctrl_inc, oh_inc;
  logic                   hand_l, hand_rt, due;
  logic [SAMPLE_BITS-1:0] diff;
  event_t                 ev_eval, ev;
  logic                   alarm_eval, oh_act_eval, primed_eval, use_eval;
  logic [TIMER_BITS-1:0]  ctrl_eval, oh_eval;
  logic [SAMPLE_BITS-1:0] prev_eval;
  logic                   alarm_consumed;

  // Pending alarm, saturating timers and sensor compares.
  always_comb begin
    alarm_p   = alarm_r | alarm_request;
    entry_inc = (entry_r == TMAX) ? entry_r : entry_r + 1'b1;
    ctrl_inc  = (ctrl_r == TMAX) ? ctrl_r : ctrl_r + 1'b1;
    if (oh_act_r && (oh_r != TMAX)) begin
      oh_inc = oh_r + 1'b1;
    end else begin
      oh_inc = oh_r;
    end
    hand_l  = left_grip >= hand_thr;
    hand_rt = right_grip >= hand_thr;
    due     = ctrl_inc >= interval;
    if (!primed_r) begin
      diff = '0;
    end else if (wheel_position >= prev_wheel_r) begin
      diff = wheel_position - prev_wheel_r;
    end else begin
      diff = prev_wheel_r - wheel_position;
    end
  end

  // Sensor evaluation: alarm first, then no hands, harsh, one hand, light.
  always_comb begin
    ev_eval        = EV_NONE;
    alarm_eval     = alarm_p;
    ctrl_eval      = ctrl_inc;
    oh_act_eval    = oh_act_r;
    oh_eval        = oh_inc;
    prev_eval      = prev_wheel_r;
    primed_eval    = primed_r;
    alarm_consumed = 1'b0;
    if (due) begin
      if (alarm_p) begin
        alarm_eval     = 1'b0;
        alarm_consumed = 1'b1;
        ev_eval        = EV_NO_HANDS;
      end else begin
        ctrl_eval   = '0;
        prev_eval   = wheel_position;
        primed_eval = 1'b1;
        if (!hand_l && !hand_rt) begin
          ev_eval = EV_NO_HANDS;
        end else if (diff >= harsh_thr) begin
          ev_eval = EV_HARSH;
        end else if (hand_l != hand_rt) begin
          if (!oh_act_r) begin
            oh_act_eval = 1'b1;
            oh_eval     = '0;
          end
          if (oh_eval >= one_hand_ms) begin
            ev_eval = EV_ONE_HAND;
          end else if (diff >= light_thr) begin
            ev_eval = EV_LIGHT;
          end
        end else begin
          oh_act_eval = 1'b0;
          if (diff >= light_thr) begin
            ev_eval = EV_LIGHT;
          end
        end
      end
    end
  end

  // Mode transitions; every transition restarts the entry timer.
  always_comb begin
    mode_nxt  = mode_r;
    entry_nxt = entry_inc;
    ev        = EV_NONE;
    use_eval  = 1'b0;
    unique case (mode_r)
      M_INIT: begin
        ev        = EV_START;
        mode_nxt  = M_WATCH;
        entry_nxt = '0;
      end
      M_WATCH: begin
        use_eval = 1'b1;
        ev       = ev_eval;
        if (ev_eval == EV_ONE_HAND || ev_eval == EV_LIGHT) begin
          mode_nxt  = M_LIGHT;
          entry_nxt = '0;
        end else if (ev_eval == EV_HARSH || ev_eval == EV_NO_HANDS) begin
          mode_nxt  = M_STRONG;
          entry_nxt = '0;
        end
      end
      M_LIGHT: begin
        if (entry_inc >= alert_to) begin
          ev        = EV_EXPIRED;
          mode_nxt  = M_WATCH;
          entry_nxt = '0;
        end else begin
          use_eval = 1'b1;
          ev       = ev_eval;
          if (ev_eval == EV_HARSH || ev_eval == EV_NO_HANDS) begin
            mode_nxt  = M_STRONG;
            entry_nxt = '0;
          end
        end
      end
      M_STRONG: begin
        if (entry_inc >= alert_to) begin
          ev        = EV_EXPIRED;
          mode_nxt  = M_WATCH;
          entry_nxt = '0;
        end else begin
          use_eval = 1'b1;
          ev       = ev_eval;
        end
      end
      M_ERROR: begin
        if (entry_inc >= error_to) begin
          ev        = EV_EXPIRED;
          mode_nxt  = M_INIT;
          entry_nxt = '0;
        end else begin
          use_eval = 1'b1;
          ev       = ev_eval;
        end
      end
      default: begin
        ev        = EV_NONE;
        mode_nxt  = M_ERROR;
        entry_nxt = '0;
      end
    endcase
  end

  // Evaluation side effects apply only when the sensors were evaluated.
  always_comb begin
    alarm_nxt      = alarm_p;
    ctrl_nxt       = ctrl_inc;
    oh_act_nxt     = oh_act_r;
    oh_nxt         = oh_inc;
    prev_wheel_nxt = prev_wheel_r;
    primed_nxt     = primed_r;
    if (use_eval) begin
      alarm_nxt      = alarm_eval;
      ctrl_nxt       = ctrl_eval;
      oh_act_nxt     = oh_act_eval;
      oh_nxt         = oh_eval;
      prev_wheel_nxt = prev_eval;
      primed_nxt     = primed_eval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_INIT;
      entry_r      <= '0;
      ctrl_r       <= '0;
      oh_act_r     <= 1'b0;
      oh_r         <= '0;
      prev_wheel_r <= '0;
      primed_r     <= 1'b0;
      alarm_r      <= 1'b0;
    end else if (adv) begin
      mode_r       <= mode_nxt;
      entry_r      <= entry_nxt;
      ctrl_r       <= ctrl_nxt;
      oh_act_r     <= oh_act_nxt;
      oh_r         <= oh_nxt;
      prev_wheel_r <= prev_wheel_nxt;
      primed_r     <= primed_nxt;
      alarm_r      <= alarm_nxt;
    end
  end

  // Result encoding from the mode after this item's transition.
  always_comb begin
    result.event_code  = ev;
    result.mode        = MODE_CODE_INIT;
    result.buzz_sel    = BUZ_OFF;
    result.vibrator_on = 1'b0;
    unique case (mode_nxt)
      M_INIT:   result.mode = MODE_CODE_INIT;
      M_WATCH:  result.mode = MODE_CODE_WATCH;
      M_LIGHT: begin
        result.mode     = MODE_CODE_LIGHT;
        result.buzz_sel = BUZ_INT;
      end
      M_STRONG: begin
        result.mode        = MODE_CODE_STRONG;
        result.buzz_sel    = BUZ_CONT;
        result.vibrator_on = 1'b1;
      end
      M_ERROR: begin
        result.mode        = MODE_CODE_ERROR;
        result.buzz_sel    = BUZ_CONT;
        result.vibrator_on = 1'b1;
      end
      default: result.mode = MODE_CODE_ERROR;
    endcase
  end

  // Init always hands over to watching on the next item.
  `HWA_ASSERT_NEXT(a_init_to_watch, adv && mode_r == M_INIT, mode_r == M_WATCH,
                   "init did not move to watching")
  // A consumed alarm leaves nothing pending.
  `HWA_ASSERT_NEXT(a_alarm_cleared, adv && use_eval && alarm_consumed, !alarm_r,
                   "consumed alarm still pending")
  // Sensor events only appear when an evaluation was due.
  `HWA_ASSERT_NOW(a_eval_when_due, use_eval && ev != EV_NONE, due,
                  "sensor event without a due evaluation")

endmodule

// ===== design/hands_on_wheel_alert_fsm.sv =====
// ---------------------------------------------------------------------------
// Hands-on-wheel alert controller
// Top level: input register, alert core, result register and config port.
// ---------------------------------------------------------------------------
// Each input item is one millisecond tick with two grip samples, a wheel
// sample and a remote alarm flag; each item yields exactly one result item
// (mode, event, buzzer mode, vibrator). The block takes one item per clock
// cycle: an item sits in the input register while the mode machine, timers
// and classification compares settle, and its result is captured in the
// result register when the item advances, so each result passes through
// the input register and then the result register. The result register
// holds a waiting result while the next item waits in the input register;
// throughput drops only while out_tready is low. Configuration writes take
// effect on the next item and are meant for idle periods.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hands_on_wheel_alert_fsm_defines.svh"

module hands_on_wheel_alert_fsm
  import hwa_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int TIMER_BITS  = 16,
  localparam int IN_W  = 3 * SAMPLE_BITS + 1,
  localparam int IN_DW = ((IN_W + 7) / 8) * 8,
  localparam int CFG_W = (SAMPLE_BITS > TIMER_BITS) ? SAMPLE_BITS : TIMER_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input item: left_grip, right_grip, wheel_position, alarm_request, zero fill
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DW-1:0]      in_tdata,
  // Result item: mode, event_code, buzz_sel, vibrator_on, zero fill
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DW-1:0]     out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic [SAMPLE_BITS-1:0] hand_thr, light_thr, harsh_thr;
  logic [TIMER_BITS-1:0]  interval, one_hand_ms, alert_to, error_to;

  logic            in_valid_r, in_valid_nxt;
  logic [IN_W-1:0] in_data_r;
  logic            out_valid_r, out_valid_nxt;
  result_t         res_r;
  result_t         res;
  logic            adv;

  hwa_cfg #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIMER_BITS  (TIMER_BITS),
    .CFG_W       (CFG_W)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .hand_thr    (hand_thr),
    .light_thr   (light_thr),
    .harsh_thr   (harsh_thr),
    .interval    (interval),
    .one_hand_ms (one_hand_ms),
    .alert_to    (alert_to),
    .error_to    (error_to)
  );

  // The held item advances when the result register is free or being drained.
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  // Input register.
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata[IN_W-1:0];
    end
  end

  hwa_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .left_grip      (in_data_r[SAMPLE_BITS-1:0]),
    .right_grip     (in_data_r[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .wheel_position (in_data_r[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .alarm_request  (in_data_r[3*SAMPLE_BITS]),
    .hand_thr       (hand_thr),
    .light_thr      (light_thr),
    .harsh_thr      (harsh_thr),
    .interval       (interval),
    .one_hand_ms    (one_hand_ms),
    .alert_to       (alert_to),
    .error_to       (error_to),
    .result         (res)
  );

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW - RESULT_W){1'b0}}, res_r};

  // A held item stays held until it can advance.
  `HWA_ASSERT_NEXT(a_in_hold, in_valid_r && !adv, in_valid_r,
                   "input item dropped while stalled")
  // A stalled result is never overwritten.
  `HWA_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_tready, !adv,
                  "result overwritten while stalled")
  // The vibrator only runs with the continuous buzzer.
  `HWA_ASSERT_NOW(a_vib_buzzer, out_valid_r && res_r.vibrator_on,
                  res_r.buzz_sel == BUZ_CONT, "vibrator without continuous buzzer")

endmodule
